>>> rtl/dwc_pkg.sv
// shared types, codes and widths for the depthwise convolution plane block
// no dependencies; imported by dwc_mac and depthwise_conv2d_plane_top
package dwc_pkg;

  localparam int unsigned DEF_MAX_HEIGHT = 64;
  localparam int unsigned DEF_MAX_WIDTH  = 64;
  localparam int unsigned DEF_KER_ROWS   = 3;
  localparam int unsigned DEF_KER_COLS   = 3;
  localparam int unsigned DEF_PIXEL_BITS = 16;

  localparam int unsigned VAL_W      = 16;
  localparam int unsigned PROD_W     = 2 * VAL_W;
  localparam int unsigned SUM_W      = 40;
  localparam int unsigned ROW_W      = 6;
  localparam int unsigned COL_W      = 6;
  localparam int unsigned TAPI_W     = 4;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned DIM_W      = 7;
  localparam int unsigned STEP_W     = 4;
  localparam int unsigned PAD_W      = 3;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned CMP_W      = 11;
  localparam int unsigned S_DATA_W   = 32;
  localparam int unsigned M_DATA_W   = 40;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;

  localparam int unsigned ROW_LSB = 0;
  localparam int unsigned COL_LSB = ROW_LSB + ROW_W;
  localparam int unsigned TAP_LSB = COL_LSB + COL_W;
  localparam int unsigned VAL_LSB = TAP_LSB + TAPI_W;

  localparam logic [DIM_W-1:0]  RST_IN_HEIGHT = 7'd64;
  localparam logic [DIM_W-1:0]  RST_IN_WIDTH  = 7'd64;
  localparam logic [STEP_W-1:0] RST_STRIDE    = 4'd1;
  localparam logic [PAD_W-1:0]  RST_PAD       = 3'd0;
  localparam logic [STEP_W-1:0] RST_DILATION  = 4'd1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_PIXEL = 2'd0,
    OP_LOAD_TAP   = 2'd1,
    OP_COMPUTE    = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_HEIGHT     = 3'd0,
    CFG_IN_WIDTH      = 3'd1,
    CFG_STRIDE_ROWS   = 3'd2,
    CFG_STRIDE_COLS   = 3'd3,
    CFG_PAD_ROWS      = 3'd4,
    CFG_PAD_COLS      = 3'd5,
    CFG_DILATION_ROWS = 3'd6,
    CFG_DILATION_COLS = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_RUN   = 2'd1,
    ST_DRAIN = 2'd2
  } state_e;

  typedef struct packed {
    logic clear;
    logic valid;
    logic last;
  } mac_ctl_t;

endpackage

>>> rtl/depthwise_conv2d_plane_top.sv
// depthwise 2-d convolution over one channel plane held in on-chip memory
// depends on dwc_pkg and dwc_mac
//
//  channel  direction  payload                                   handshake
//  s_axis   in         tuser: op; tdata: row, col, tap_index,   tvalid/tready
//                      value
//  m_axis   out        tdata: sum                                tvalid/tready
//  cfg      in         cfg_index_i, cfg_data_i                   cfg_valid_i/cfg_ready_o
//
// a compute transaction reads the plane memory once per kernel tap inside the
// plane, then passes through the memory, multiply and accumulate registers
// the result waits in the output register; a compute stalls at its end until
// that register is free, and no loads are accepted until it completes
// reset clears control, presets configuration; plane and tap memories are not cleared
module depthwise_conv2d_plane_top #(
  parameter int unsigned MAX_HEIGHT = dwc_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned MAX_WIDTH  = dwc_pkg::DEF_MAX_WIDTH,
  parameter int unsigned KER_ROWS   = dwc_pkg::DEF_KER_ROWS,
  parameter int unsigned KER_COLS   = dwc_pkg::DEF_KER_COLS,
  parameter int unsigned PIXEL_BITS = dwc_pkg::DEF_PIXEL_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // row [5:0], col [11:6], tap_index [15:12], value [31:16]
  input  logic [dwc_pkg::S_DATA_W-1:0]      s_axis_tdata,
  // op [1:0]
  input  logic [dwc_pkg::OP_W-1:0]          s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // sum [39:0]
  output logic [dwc_pkg::M_DATA_W-1:0]      m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dwc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [dwc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import dwc_pkg::*;

  localparam int unsigned PLANE_DEPTH = MAX_HEIGHT * MAX_WIDTH;
  localparam int unsigned ADDR_W      = (PLANE_DEPTH > 1) ? $clog2(PLANE_DEPTH) : 1;
  localparam int unsigned TAP_DEPTH   = KER_ROWS * KER_COLS;
  localparam int unsigned TAP_AW      = (TAP_DEPTH > 1) ? $clog2(TAP_DEPTH) : 1;
  localparam int unsigned KH_W        = (KER_ROWS > 1) ? $clog2(KER_ROWS) : 1;
  localparam int unsigned KW_W        = (KER_COLS > 1) ? $clog2(KER_COLS) : 1;
  localparam int unsigned KEEP_W      = (PIXEL_BITS < VAL_W) ? PIXEL_BITS : VAL_W;

  // configuration registers
  logic [DIM_W-1:0]  in_height_q, in_width_q;
  logic [STEP_W-1:0] stride_rows_q, stride_cols_q, dil_rows_q, dil_cols_q;
  logic [PAD_W-1:0]  pad_rows_q, pad_cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_height_q   <= RST_IN_HEIGHT;
      in_width_q    <= RST_IN_WIDTH;
      stride_rows_q <= RST_STRIDE;
      stride_cols_q <= RST_STRIDE;
      pad_rows_q    <= RST_PAD;
      pad_cols_q    <= RST_PAD;
      dil_rows_q    <= RST_DILATION;
      dil_cols_q    <= RST_DILATION;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_IN_HEIGHT:     in_height_q   <= cfg_data_i[DIM_W-1:0];
        CFG_IN_WIDTH:      in_width_q    <= cfg_data_i[DIM_W-1:0];
        CFG_STRIDE_ROWS:   stride_rows_q <= cfg_data_i[STEP_W-1:0];
        CFG_STRIDE_COLS:   stride_cols_q <= cfg_data_i[STEP_W-1:0];
        CFG_PAD_ROWS:      pad_rows_q    <= cfg_data_i[PAD_W-1:0];
        CFG_PAD_COLS:      pad_cols_q    <= cfg_data_i[PAD_W-1:0];
        CFG_DILATION_ROWS: dil_rows_q    <= cfg_data_i[STEP_W-1:0];
        CFG_DILATION_COLS: dil_cols_q    <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // input field split
  logic [ROW_W-1:0]         in_row;
  logic [COL_W-1:0]         in_col;
  logic [TAPI_W-1:0]        in_tap;
  logic signed [KEEP_W-1:0] in_keep;
  logic signed [VAL_W-1:0]  wr_val;

  assign in_row  = s_axis_tdata[ROW_LSB +: ROW_W];
  assign in_col  = s_axis_tdata[COL_LSB +: COL_W];
  assign in_tap  = s_axis_tdata[TAP_LSB +: TAPI_W];
  assign in_keep = s_axis_tdata[VAL_LSB +: KEEP_W];
  assign wr_val  = VAL_W'(in_keep);

  // control
  state_e state_q, state_d;
  logic   s_acc, is_pixel, is_tap, is_compute;
  logic   run, last_tap, out_load, mac_done;

  assign s_acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    is_pixel   = 1'b0;
    is_tap     = 1'b0;
    is_compute = 1'b0;
    case (op_e'(s_axis_tuser))
      OP_LOAD_PIXEL: is_pixel   = 1'b1;
      OP_LOAD_TAP:   is_tap     = 1'b1;
      OP_COMPUTE:    is_compute = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    run           = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && is_compute) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        run = 1'b1;
        if (last_tap) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mac_done && (!m_axis_tvalid || m_axis_tready)) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // window walk
  logic [KH_W-1:0]    kh_q;
  logic [KW_W-1:0]    kw_q;
  logic [TAP_AW-1:0]  tap_cnt_q;
  logic [COORD_W-1:0] h_q, w_q, w0_q, h0, w0;
  logic [DIM_W-1:0]   eff_h_q, eff_w_q, eff_h, eff_w;
  logic [ROW_W+STEP_W-1:0] row_mul, col_mul;

  assign row_mul  = in_row * stride_rows_q;
  assign col_mul  = in_col * stride_cols_q;
  assign h0       = COORD_W'(row_mul) - COORD_W'(pad_rows_q);
  assign w0       = COORD_W'(col_mul) - COORD_W'(pad_cols_q);
  assign eff_h    = (CMP_W'(in_height_q) > CMP_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                                : in_height_q;
  assign eff_w    = (CMP_W'(in_width_q) > CMP_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH)
                                                              : in_width_q;
  assign last_tap = (kh_q == KH_W'(KER_ROWS - 1)) && (kw_q == KW_W'(KER_COLS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kh_q      <= '0;
      kw_q      <= '0;
      tap_cnt_q <= '0;
    end else if (s_acc && is_compute) begin
      kh_q      <= '0;
      kw_q      <= '0;
      tap_cnt_q <= '0;
    end else if (run) begin
      tap_cnt_q <= tap_cnt_q + TAP_AW'(1);
      if (kw_q == KW_W'(KER_COLS - 1)) begin
        kw_q <= '0;
        kh_q <= kh_q + KH_W'(1);
      end else begin
        kw_q <= kw_q + KW_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc && is_compute) begin
      h_q     <= h0;
      w_q     <= w0;
      w0_q    <= w0;
      eff_h_q <= eff_h;
      eff_w_q <= eff_w;
    end else if (run) begin
      if (kw_q == KW_W'(KER_COLS - 1)) begin
        w_q <= w0_q;
        h_q <= h_q + COORD_W'(dil_rows_q);
      end else begin
        w_q <= w_q + COORD_W'(dil_cols_q);
      end
    end
  end

  logic              in_range;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              pix_we, tap_we;

  assign in_range = !h_q[COORD_W-1] && (h_q[COORD_W-2:0] < (COORD_W-1)'(eff_h_q))
                 && !w_q[COORD_W-1] && (w_q[COORD_W-2:0] < (COORD_W-1)'(eff_w_q));
  assign rd_addr  = ADDR_W'(h_q[DIM_W-1:0]) * ADDR_W'(MAX_WIDTH)
                  + ADDR_W'(w_q[DIM_W-1:0]);
  assign wr_addr  = ADDR_W'(in_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col);
  assign pix_we   = s_acc && is_pixel && (CMP_W'(in_row) < CMP_W'(MAX_HEIGHT))
                 && (CMP_W'(in_col) < CMP_W'(MAX_WIDTH));
  assign tap_we   = s_acc && is_tap && (CMP_W'(in_tap) < CMP_W'(TAP_DEPTH));

  // plane and tap memories
  logic signed [VAL_W-1:0] plane_mem [PLANE_DEPTH];
  logic signed [VAL_W-1:0] tap_mem [TAP_DEPTH];
  logic signed [VAL_W-1:0] px_q, tp_q;

  always_ff @(posedge clk_i) begin
    if (pix_we) begin
      plane_mem[wr_addr] <= wr_val;
    end
    if (run && in_range) begin
      px_q <= plane_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tap_we) begin
      tap_mem[TAP_AW'(in_tap)] <= wr_val;
    end
    if (run) begin
      tp_q <= tap_mem[tap_cnt_q];
    end
  end

  // multiply-accumulate
  mac_ctl_t                mac_ctl;
  logic signed [SUM_W-1:0] mac_acc;

  assign mac_ctl.clear = s_acc && is_compute;
  assign mac_ctl.valid = run && in_range;
  assign mac_ctl.last  = run && last_tap;

  dwc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .px_i   (px_q),
    .tp_i   (tp_q),
    .acc_o  (mac_acc),
    .done_o (mac_done)
  );

  // output register
  logic                m_valid_q;
  logic [M_DATA_W-1:0] m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= M_DATA_W'(mac_acc);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

>>> rtl/dwc_mac.sv
// multiply-accumulate pipeline behind the plane and tap memory read ports
// depends on dwc_pkg
module dwc_mac (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dwc_pkg::mac_ctl_t                ctl_i,
  input  logic signed [dwc_pkg::VAL_W-1:0] px_i,
  input  logic signed [dwc_pkg::VAL_W-1:0] tp_i,
  output logic signed [dwc_pkg::SUM_W-1:0] acc_o,
  output logic                             done_o
);
  import dwc_pkg::*;

  logic                     v1_q, last1_q, v2_q, last2_q, done_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SUM_W-1:0]  acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      last1_q <= 1'b0;
      v2_q    <= 1'b0;
      last2_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      v1_q    <= ctl_i.valid;
      last1_q <= ctl_i.last;
      v2_q    <= v1_q;
      last2_q <= last1_q;
      if (ctl_i.clear) begin
        done_q <= 1'b0;
      end else if (last2_q) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      prod_q <= px_i * tp_i;
    end
    if (ctl_i.clear) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + SUM_W'(prod_q);
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

>>> tb/sv/tb_depthwise_conv2d_plane_top.sv
// self-checking testbench for depthwise_conv2d_plane_top: random and directed loads and computes
// over several geometries, with a window-sum predictor checked against every output transaction
// depends on dwc_pkg and the rtl of depthwise_conv2d_plane_top
`timescale 1ns / 1ps

module tb_depthwise_conv2d_plane_top;
  import dwc_pkg::*;

  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
  localparam int unsigned TAP_CNT   = DEF_KER_ROWS * DEF_KER_COLS;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned SETTLE    = 20;
  localparam int unsigned LIMIT     = 1000000;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [TAPI_W-1:0] tap;
    logic [VAL_W-1:0]  value;
  } stim_t;

  typedef struct packed {
    logic [DIM_W-1:0]  h;
    logic [DIM_W-1:0]  w;
    logic [STEP_W-1:0] sr;
    logic [STEP_W-1:0] sc;
    logic [PAD_W-1:0]  pr;
    logic [PAD_W-1:0]  pc;
    logic [STEP_W-1:0] dr;
    logic [STEP_W-1:0] dc;
  } geom_t;

  localparam geom_t RST_GEOM = '{RST_IN_HEIGHT, RST_IN_WIDTH, RST_STRIDE, RST_STRIDE,
                                 RST_PAD, RST_PAD, RST_DILATION, RST_DILATION};

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata = '0;
  logic [OP_W-1:0]       s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_axis_tdata;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  stim_t              pend_q[$];
  stim_t              drv_item;
  logic [SUM_W-1:0]   conv_sum_q[$];
  logic signed [VAL_W-1:0] plane_img [DEF_MAX_HEIGHT*DEF_MAX_WIDTH];
  logic signed [VAL_W-1:0] tap_coef [TAP_CNT];
  bit                 pix_seen [DEF_MAX_HEIGHT*DEF_MAX_WIDTH];
  geom_t              pred_geom = RST_GEOM;
  geom_t              gen_geom = RST_GEOM;
  int unsigned        n_pushed = 0;
  int unsigned        n_counted = 0;
  int unsigned        n_accepted = 0;
  int unsigned        err_cnt = 0;
  int unsigned        cyc = 0;
  int unsigned        src_gap = 0;
  int unsigned        snk_gap = 0;
  int unsigned        hold_left = 0;
  bit                 hold_go = 1'b0;
  bit                 hold_done = 1'b0;
  bit                 idle_on = 1'b1;

  depthwise_conv2d_plane_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic geom_t with_reg(input geom_t g, input cfg_idx_e idx,
                                     input logic [CFG_DATA_W-1:0] d);
    geom_t n;
    n = g;
    case (idx)
      CFG_IN_HEIGHT:     n.h = d;
      CFG_IN_WIDTH:      n.w = d;
      CFG_STRIDE_ROWS:   n.sr = d[STEP_W-1:0];
      CFG_STRIDE_COLS:   n.sc = d[STEP_W-1:0];
      CFG_PAD_ROWS:      n.pr = d[PAD_W-1:0];
      CFG_PAD_COLS:      n.pc = d[PAD_W-1:0];
      CFG_DILATION_ROWS: n.dr = d[STEP_W-1:0];
      CFG_DILATION_COLS: n.dc = d[STEP_W-1:0];
      default: ;
    endcase
    return n;
  endfunction

  // plane address read by kernel tap k of output (orow, ocol); returns 0 if it falls outside the plane
  function automatic bit tap_addr(input geom_t g, input int orow, input int ocol,
                                  input int k, output int addr);
    int eh, ew, h, w;
    eh = (g.h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(g.h);
    ew = (g.w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(g.w);
    h = orow * int'(g.sr) - int'(g.pr) + (k / DEF_KER_COLS) * int'(g.dr);
    w = ocol * int'(g.sc) - int'(g.pc) + (k % DEF_KER_COLS) * int'(g.dc);
    addr = h * DEF_MAX_WIDTH + w;
    return h >= 0 && h < eh && w >= 0 && w < ew;
  endfunction

  function automatic logic [SUM_W-1:0] window_sum(input int orow, input int ocol);
    longint acc;
    int a;
    acc = 0;
    for (int k = 0; k < TAP_CNT; k++) begin
      if (tap_addr(pred_geom, orow, ocol, k, a))
        acc += longint'(plane_img[a]) * longint'(tap_coef[k]);
    end
    return acc[SUM_W-1:0];
  endfunction

  function automatic void absorb_item(input logic [OP_W-1:0] op, input logic [S_DATA_W-1:0] d);
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    logic [TAPI_W-1:0] t;
    r = d[COL_LSB-1:ROW_LSB];
    c = d[TAP_LSB-1:COL_LSB];
    t = d[VAL_LSB-1:TAP_LSB];
    case (op)
      OP_LOAD_PIXEL: plane_img[{r, c}] = d[S_DATA_W-1:VAL_LSB];
      OP_LOAD_TAP:   if (t < TAP_CNT) tap_coef[t] = d[S_DATA_W-1:VAL_LSB];
      OP_COMPUTE:    conv_sum_q.push_back(window_sum(int'(r), int'(c)));
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("mismatch: %s", msg);
  endtask

  function automatic logic [VAL_W-1:0] rand_val();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic void push_item(input logic [OP_W-1:0] op, input logic [ROW_W-1:0] r,
                                    input logic [COL_W-1:0] c, input logic [TAPI_W-1:0] t,
                                    input logic [VAL_W-1:0] v);
    pend_q.push_back('{op, r, c, t, v});
    n_pushed++;
    if (op == OP_LOAD_PIXEL) pix_seen[{r, c}] = 1'b1;
    if (op != OP_RESERVED && !(op == OP_LOAD_TAP && t >= TAP_CNT)) n_counted++;
  endfunction

  // pixels under the window that were never loaded get loaded first
  function automatic void push_compute(input int r, input int c);
    int a;
    for (int k = 0; k < TAP_CNT; k++) begin
      if (tap_addr(gen_geom, r, c, k, a) && !pix_seen[a])
        push_item(OP_LOAD_PIXEL, ROW_W'(a / DEF_MAX_WIDTH), COL_W'(a % DEF_MAX_WIDTH),
                  TAPI_W'($urandom), rand_val());
    end
    push_item(OP_COMPUTE, ROW_W'(r), COL_W'(c), TAPI_W'($urandom), VAL_W'($urandom));
  endfunction

  function automatic int out_span(input int eff, input int pad, input int step);
    int m;
    if (step == 0) return 63;
    m = (eff + pad) / step + 1;
    return (m > 63) ? 63 : m;
  endfunction

  function automatic geom_t rand_geom();
    geom_t g;
    g.h = ($urandom_range(0, 3) == 0) ? DIM_W'($urandom) : DIM_W'($urandom_range(1, 12));
    g.w = ($urandom_range(0, 3) == 0) ? DIM_W'($urandom) : DIM_W'($urandom_range(1, 12));
    g.sr = ($urandom_range(0, 2) == 0) ? STEP_W'($urandom) : STEP_W'($urandom_range(1, 3));
    g.sc = ($urandom_range(0, 2) == 0) ? STEP_W'($urandom) : STEP_W'($urandom_range(1, 3));
    g.pr = PAD_W'($urandom);
    g.pc = PAD_W'($urandom);
    g.dr = ($urandom_range(0, 2) == 0) ? STEP_W'($urandom) : STEP_W'($urandom_range(1, 3));
    g.dc = ($urandom_range(0, 2) == 0) ? STEP_W'($urandom) : STEP_W'($urandom_range(1, 3));
    return g;
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] d);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    gen_geom = with_reg(gen_geom, idx, d);
  endtask

  // unused upper data bits carry random values
  task automatic program_geom(input geom_t g);
    write_reg(CFG_IN_HEIGHT, g.h);
    write_reg(CFG_IN_WIDTH, g.w);
    write_reg(CFG_STRIDE_ROWS, {3'($urandom), g.sr});
    write_reg(CFG_STRIDE_COLS, {3'($urandom), g.sc});
    write_reg(CFG_PAD_ROWS, {4'($urandom), g.pr});
    write_reg(CFG_PAD_COLS, {4'($urandom), g.pc});
    write_reg(CFG_DILATION_ROWS, {3'($urandom), g.dr});
    write_reg(CFG_DILATION_COLS, {3'($urandom), g.dc});
  endtask

  task automatic settle();
    while (n_accepted != n_pushed || conv_sum_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned stop, pick;
    int eh, ew;
    stop = n_counted + n;
    while (n_counted < stop) begin
      eh = (gen_geom.h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(gen_geom.h);
      ew = (gen_geom.w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(gen_geom.w);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        if ($urandom_range(0, 4) == 0)
          push_compute($urandom_range(0, 63), $urandom_range(0, 63));
        else
          push_compute($urandom_range(0, out_span(eh, int'(gen_geom.pr), int'(gen_geom.sr))),
                       $urandom_range(0, out_span(ew, int'(gen_geom.pc), int'(gen_geom.sc))));
      end else if (pick < 80) begin
        if (eh != 0 && ew != 0 && $urandom_range(0, 3) != 0)
          push_item(OP_LOAD_PIXEL, ROW_W'($urandom_range(0, eh - 1)),
                    COL_W'($urandom_range(0, ew - 1)), TAPI_W'($urandom), rand_val());
        else
          push_item(OP_LOAD_PIXEL, ROW_W'($urandom), COL_W'($urandom), TAPI_W'($urandom),
                    rand_val());
      end else if (pick < 95) begin
        push_item(OP_LOAD_TAP, ROW_W'($urandom), COL_W'($urandom),
                  (pick < 93) ? TAPI_W'($urandom_range(0, TAP_CNT - 1)) : TAPI_W'($urandom),
                  rand_val());
      end else begin
        push_item(OP_RESERVED, ROW_W'($urandom), COL_W'($urandom), TAPI_W'($urandom),
                  VAL_W'($urandom));
      end
    end
  endtask

  // input stream driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_gap <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (src_gap != 0) begin
        src_gap <= src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pend_q.size() != 0) begin
        drv_item = pend_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= drv_item.op;
        s_axis_tdata  <= {drv_item.value, drv_item.tap, drv_item.col, drv_item.row};
        if (idle_on && $urandom_range(0, 7) == 0) src_gap <= $urandom_range(1, 19);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_go && !hold_done) begin
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // output stream sink
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      snk_gap <= 0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
    end else if (snk_gap != 0) begin
      snk_gap <= snk_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (idle_on && $urandom_range(0, 9) == 0) snk_gap <= $urandom_range(1, 19);
    end
  end

  // monitor: config and input transactions feed the predictor, outputs are checked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o)
        pred_geom = with_reg(pred_geom, cfg_idx_e'(cfg_index_i), cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_item(s_axis_tuser, s_axis_tdata);
        n_accepted++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (conv_sum_q.size() == 0)
          report_mismatch($sformatf("sum %h with no compute pending", m_axis_tdata));
        else if (m_axis_tdata !== conv_sum_q[0])
          report_mismatch($sformatf("sum %h, want %h", m_axis_tdata, conv_sum_q[0]));
        if (conv_sum_q.size() != 0) void'(conv_sum_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // largest positive sum, then mixed signs, ignored items and border windows
    for (int k = 0; k < TAP_CNT; k++)
      push_item(OP_LOAD_TAP, ROW_W'($urandom), COL_W'($urandom), TAPI_W'(k), 16'h8000);
    for (int k = 0; k < TAP_CNT; k++)
      push_item(OP_LOAD_PIXEL, ROW_W'(k / DEF_KER_COLS), COL_W'(k % DEF_KER_COLS),
                TAPI_W'($urandom), 16'h8000);
    push_compute(0, 0);
    push_item(OP_LOAD_TAP, ROW_W'($urandom), COL_W'($urandom), 4'd4, 16'h7fff);
    push_item(OP_LOAD_TAP, ROW_W'($urandom), COL_W'($urandom), 4'd9, rand_val());
    push_item(OP_LOAD_TAP, ROW_W'($urandom), COL_W'($urandom), 4'd15, rand_val());
    push_item(OP_RESERVED, ROW_W'($urandom), COL_W'($urandom), TAPI_W'($urandom), rand_val());
    push_compute(0, 0);
    push_compute(63, 63);
    push_compute(0, 63);
    run_random(150);

    settle();
    program_geom('{7'd64, 7'd64, 4'd1, 4'd1, 3'd7, 3'd7, 4'd8, 4'd8});
    run_random(100);

    settle();
    program_geom('{7'd8, 7'd8, 4'd2, 4'd2, 3'd1, 3'd1, 4'd2, 4'd2});
    run_random(120);
    @(posedge clk_i);
    hold_go <= 1'b1;

    settle();
    program_geom('{7'd1, 7'd1, 4'd1, 4'd1, 3'd0, 3'd0, 4'd1, 4'd1});
    run_random(60);

    settle();
    program_geom('{7'd127, 7'd127, 4'd15, 4'd15, 3'd7, 3'd7, 4'd15, 4'd15});
    run_random(60);

    settle();
    program_geom('{7'd0, 7'd5, 4'd1, 4'd1, 3'd1, 3'd1, 4'd1, 4'd1});
    run_random(40);

    settle();
    program_geom('{7'd6, 7'd0, 4'd1, 4'd1, 3'd1, 3'd1, 4'd1, 4'd1});
    run_random(40);

    settle();
    program_geom('{7'd7, 7'd9, 4'd0, 4'd0, 3'd1, 3'd2, 4'd0, 4'd0});
    run_random(80);

    while (n_counted < 1150) begin
      settle();
      program_geom(rand_geom());
      run_random(100);
    end

    settle();
    idle_on <= 1'b0;
    program_geom(rand_geom());
    run_random(150);

    settle();
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/dwc_pkg.sv
rtl/dwc_mac.sv
rtl/depthwise_conv2d_plane_top.sv
tb/sv/tb_depthwise_conv2d_plane_top.sv
